>>> sv/amt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the alarm table.
`default_nettype none

package amt_pkg;

    // Table depth (range 1 to 64)
    localparam int ENTRIES = 16;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int ACT_W   = 2;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;

    localparam int ENTRY_W = HOUR_W + MIN_W;

    // Common width for rank/seen and count/saturation compares
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CHECK  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic load_out;
    } amt_cmd_t;

    typedef struct packed {
        logic done;
    } amt_stat_t;

endpackage

`default_nettype wire

>>> sv/amt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/amt_ctrl.sv
// Controller state machine: accept a request, run the table scan, hand off the result.
`default_nettype none

module amt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output amt_pkg::amt_cmd_t       cmd,
    input  wire amt_pkg::amt_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Never overwrite a result that is still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

>>> sv/amt_dp.sv
// Datapath: request registers, entry store, valid bits, scan pipeline and result registers.
`default_nettype none

module amt_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire amt_pkg::amt_cmd_t                  cmd,
    output amt_pkg::amt_stat_t                      stat,
    input  wire logic [amt_pkg::ACT_W-1:0]          in_action,
    input  wire logic [amt_pkg::HOUR_W-1:0]         in_hour,
    input  wire logic [amt_pkg::MIN_W-1:0]          in_minute,
    input  wire logic [amt_pkg::RANK_W-1:0]         in_rank,
    output logic                                    out_ok,
    output logic      [amt_pkg::COUNT_W-1:0]        out_count,
    output logic      [amt_pkg::HOUR_W-1:0]         out_hour,
    output logic      [amt_pkg::MIN_W-1:0]          out_minute
);

    localparam int IDX_W = amt_pkg::IDX_W;
    localparam int CNT_W = amt_pkg::CNT_W;
    localparam int CMP_W = amt_pkg::CMP_W;

    // Request payload
    amt_pkg::action_t             act_reg;
    logic [amt_pkg::HOUR_W-1:0]   hour_reg;
    logic [amt_pkg::MIN_W-1:0]    min_reg;
    logic [amt_pkg::RANK_W-1:0]   rank_reg;

    // Scan pipeline: issue stage drives the RAM address, compare stage sees its data
    logic [IDX_W:0]               issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic                         cmp_live_reg, cmp_live_next;
    logic [CNT_W-1:0]             seen_reg, seen_next;

    logic [amt_pkg::ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic                         res_ok_reg;
    logic [amt_pkg::HOUR_W-1:0]   res_hour_reg;
    logic [amt_pkg::MIN_W-1:0]    res_min_reg;

    logic [amt_pkg::ENTRY_W-1:0]  rdata;
    logic                         ram_we;
    logic                         issue_live;
    logic                         cur_valid;
    logic                         hit;
    logic                         done;
    logic [CMP_W-1:0]             cnt_wide;

    amt_ram #(
        .WIDTH (amt_pkg::ENTRY_W),
        .DEPTH (amt_pkg::ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmp_idx_reg),
        .wdata ({hour_reg, min_reg}),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign issue_live = (issue_cnt_reg < (IDX_W + 1)'(amt_pkg::ENTRIES));
    assign cur_valid  = valid_reg[cmp_idx_reg];

    always_comb
    begin
        case (act_reg)
            amt_pkg::ACT_ADD:    hit = !cur_valid;
            amt_pkg::ACT_REMOVE: hit = cur_valid && (rdata == {hour_reg, min_reg});
            amt_pkg::ACT_CHECK:  hit = cur_valid && (rdata == {hour_reg, min_reg});
            amt_pkg::ACT_READ:   hit = cur_valid && (CMP_W'(seen_reg) == CMP_W'(rank_reg));
            default:             hit = 1'b0;
        endcase
    end

    assign done      = cmd.scan && cmp_live_reg
                       && (hit || (cmp_idx_reg == IDX_W'(amt_pkg::ENTRIES - 1)));
    assign stat.done = done;
    assign ram_we    = done && hit && (act_reg == amt_pkg::ACT_ADD);

    always_comb
    begin
        issue_cnt_next = issue_cnt_reg;
        cmp_live_next  = cmp_live_reg;
        seen_next      = seen_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        if (cmd.start)
        begin
            issue_cnt_next = '0;
            cmp_live_next  = 1'b0;
            seen_next      = '0;
        end
        else if (cmd.scan)
        begin
            cmp_live_next = issue_live && !done;
            if (issue_live)
            begin
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
            if (cmp_live_reg && cur_valid && !hit)
            begin
                seen_next = seen_reg + 1'b1;
            end
            if (done && hit)
            begin
                case (act_reg)
                    amt_pkg::ACT_ADD:
                    begin
                        valid_next[cmp_idx_reg] = 1'b1;
                        count_next              = count_reg + 1'b1;
                    end
                    amt_pkg::ACT_REMOVE,
                    amt_pkg::ACT_CHECK:
                    begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        count_next              = count_reg - 1'b1;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            cmp_live_reg  <= 1'b0;
            seen_reg      <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            issue_cnt_reg <= issue_cnt_next;
            cmp_live_reg  <= cmp_live_next;
            seen_reg      <= seen_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
        end
    end

    assign cnt_wide = CMP_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg  <= amt_pkg::action_t'(in_action);
            hour_reg <= in_hour;
            min_reg  <= in_minute;
            rank_reg <= in_rank;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        end
        if (done)
        begin
            res_ok_reg <= hit;
            if (hit && (act_reg == amt_pkg::ACT_READ))
            begin
                res_hour_reg <= rdata[amt_pkg::ENTRY_W-1:amt_pkg::MIN_W];
                res_min_reg  <= rdata[amt_pkg::MIN_W-1:0];
            end
            else
            begin
                res_hour_reg <= '0;
                res_min_reg  <= '0;
            end
        end
        if (cmd.load_out)
        begin
            out_ok     <= res_ok_reg;
            out_hour   <= res_hour_reg;
            out_minute <= res_min_reg;
            if (cnt_wide > CMP_W'(31))
            begin
                out_count <= amt_pkg::COUNT_W'(31);
            end
            else
            begin
                out_count <= cnt_wide[amt_pkg::COUNT_W-1:0];
            end
        end
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("valid count out of step with valid bits");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit && (act_reg == amt_pkg::ACT_ADD)) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("successful add did not raise the count");

    a_no_hold_change: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.scan |=> (valid_reg == $past(valid_reg)))
        else $error("valid bits changed outside a scan");

endmodule

`default_nettype wire

>>> sv/alarm_match_table_unit.sv
// Top level of the alarm match table: stream ports, controller and datapath.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tuser action, s_tdata hour/minute/rank
//  m_*       out        m_tvalid/m_tready   m_tuser ok, m_tdata count/hour/minute
//
// Each request is accepted, then the store is scanned entry by entry through the
// registered RAM read, and the result register is loaded last. The scan stops early
// on the first hit.
// Reset (rst_n, async, active low) clears all valid bits, the count and the handshakes.
// A result waiting on m_tready does not block the next request; that request's result
// holds in the datapath until the output register frees up.
`default_nettype none

module alarm_match_table_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [4:0] hour, [10:5] minute, [14:11] rank, [15] zero
    input  wire logic [amt_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] action
    input  wire logic [amt_pkg::ACT_W-1:0]           s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [4:0] valid_count, [9:5] entry_hour, [15:10] entry_minute
    output logic      [amt_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] ok
    output logic                                     m_tuser
);

    amt_pkg::amt_cmd_t  cmd;
    amt_pkg::amt_stat_t stat;

    logic [amt_pkg::COUNT_W-1:0] out_count;
    logic [amt_pkg::HOUR_W-1:0]  out_hour;
    logic [amt_pkg::MIN_W-1:0]   out_minute;

    amt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Unpack the request fields from the low bits up
    amt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_hour    (s_tdata[4:0]),
        .in_minute  (s_tdata[10:5]),
        .in_rank    (s_tdata[14:11]),
        .out_ok     (m_tuser),
        .out_count  (out_count),
        .out_hour   (out_hour),
        .out_minute (out_minute)
    );

    assign m_tdata = {out_minute, out_hour, out_count};

endmodule

`default_nettype wire
